/* rtl/kvbpe_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvbpe_pkg
// Shared types, constants and the CRC32C byte step for the prefix-compressed
// key-value block encoder.
// ---------------------------------------------------------------------------
package kvbpe_pkg;

	localparam int MAX_KEY_BYTES_DEF = 64;
	localparam int MAX_ENTRIES_DEF   = 64;

	localparam logic [31:0] CRC_POLY      = 32'h82F63B78;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [31:0] TRAILER_MAGIC = 32'd4;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_TRUNC = 2'd1;
	localparam logic [1:0] ERR_DROP  = 2'd2;

	typedef enum logic [1:0] {
		CMD_KEY = 2'd0,
		CMD_END = 2'd1,
		CMD_VAL = 2'd2,
		CMD_FIN = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KSTART,
		ST_KRD,
		ST_KCHK,
		ST_KHDR,
		ST_WPUT,
		ST_SRD,
		ST_SPUT,
		ST_KDONE,
		ST_FRD,
		ST_FLD,
		ST_FCNT,
		ST_FCRC,
		ST_FFOUR,
		ST_FCLR
	} state_t;

	typedef struct packed {
		logic take;
		logic first_sel;
		logic cmp_inc;
		logic hdr_load;
		logic suf_put;
		logic off_load;
		logic cnt_load;
		logic crc_load;
		logic four_load;
		logic word_put;
		logic key_done;
		logic clear;
	} dp_ctl_t;

	typedef struct packed {
		logic first;
		logic cmp_more;
		logic suf_left;
		logic word_last;
		logic ent_left;
		logic can_push;
	} dp_sts_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

/* rtl/kv_block_prefix_encoder_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kv_block_prefix_encoder_core
// Prefix-compressed key-value block builder with CRC32C trailer.
// ---------------------------------------------------------------------------
// Key and value bytes are taken as they are accepted. End of key is
// followed by a setup step. For any key but the block's first, it then runs
// a byte-serial compare against the first key: a registered key buffer read
// and a check per shared byte, and a final check to end the compare.
// The 4-byte header takes a load step and four byte steps. Each suffix byte
// takes a read step and a put step, and a done step closes the entry. Finish
// walks the recorded offsets (table read, load, then one byte per cycle
// through the packer while the output is not stalled), then puts out the
// count, CRC and trailer words (a load and four bytes each) and clears.
// Output is packed up to eight bytes per transaction; downstream stalls
// hold the byte packer.
module kv_block_prefix_encoder_core import kvbpe_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
	parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] chunk_data,
	output logic [3:0]  chunk_bytes,
	output logic        last,
	output logic [1:0]  error
);

	dp_ctl_t ctl;
	dp_sts_t sts;

	kvbpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts),
		.ctl      (ctl)
	);

	kvbpe_dp #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES),
		.MAX_ENTRIES   (MAX_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data        (data),
		.ctl         (ctl),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chunk_data  (chunk_data),
		.chunk_bytes (chunk_bytes),
		.last        (last),
		.error       (error)
	);

endmodule

/* rtl/kvbpe_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvbpe_ctrl
// Sequencer: accepts commands, walks prefix compare, header and suffix
// emission, and the finish trailer.
// ---------------------------------------------------------------------------
module kvbpe_ctrl import kvbpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic [1:0] cmd,
	input  dp_sts_t sts,
	output dp_ctl_t ctl
);

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE) && sts.can_push;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					case (cmd_t'(cmd))
						CMD_END: state_d = ST_KSTART;
						CMD_FIN: state_d = ST_FRD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_KSTART: state_d = sts.first ? ST_KHDR : ST_KRD;
			ST_KRD:    state_d = ST_KCHK;
			ST_KCHK:   state_d = sts.cmp_more ? ST_KRD : ST_KHDR;
			ST_KHDR: begin
				state_d = ST_WPUT;
				ret_d   = ST_SRD;
			end
			ST_WPUT: begin
				if (sts.can_push && sts.word_last) state_d = ret_q;
			end
			ST_SRD:  state_d = sts.suf_left ? ST_SPUT : ST_KDONE;
			ST_SPUT: begin
				if (sts.can_push) state_d = ST_SRD;
			end
			ST_KDONE: state_d = ST_IDLE;
			ST_FRD:   state_d = sts.ent_left ? ST_FLD : ST_FCNT;
			ST_FLD: begin
				state_d = ST_WPUT;
				ret_d   = ST_FRD;
			end
			ST_FCNT: begin
				state_d = ST_WPUT;
				ret_d   = ST_FCRC;
			end
			ST_FCRC: begin
				state_d = ST_WPUT;
				ret_d   = ST_FFOUR;
			end
			ST_FFOUR: begin
				state_d = ST_WPUT;
				ret_d   = ST_FCLR;
			end
			ST_FCLR: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE:   ctl.take      = in_valid && in_ready;
			ST_KSTART: ctl.first_sel = sts.first;
			ST_KCHK:   ctl.cmp_inc   = sts.cmp_more;
			ST_KHDR:   ctl.hdr_load  = 1'b1;
			ST_WPUT:   ctl.word_put  = sts.can_push;
			ST_SPUT:   ctl.suf_put   = sts.can_push;
			ST_KDONE:  ctl.key_done  = 1'b1;
			ST_FLD:    ctl.off_load  = 1'b1;
			ST_FCNT:   ctl.cnt_load  = 1'b1;
			ST_FCRC:   ctl.crc_load  = 1'b1;
			ST_FFOUR:  ctl.four_load = 1'b1;
			ST_FCLR:   ctl.clear     = 1'b1;
			default:   ctl = '0;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WPUT && sts.can_push && sts.word_last) |=> (state_q == ret_q ||
		state_q == ST_SRD || state_q == ST_FRD || state_q == ST_FCRC ||
		state_q == ST_FFOUR || state_q == ST_FCLR))
		else $error("word emission returned to an unexpected state");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.take, ctl.suf_put, ctl.word_put}))
		else $error("more than one byte source active");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FCLR) |=> (state_q == ST_IDLE))
		else $error("finish did not return to idle");

endmodule

/* rtl/kvbpe_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kvbpe_dp
// Datapath: key buffers, offset table, CRC and length, byte packer and the
// output register.
// ---------------------------------------------------------------------------
module kvbpe_dp import kvbpe_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
	parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data,
	input  dp_ctl_t     ctl,
	output dp_sts_t     sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] chunk_data,
	output logic [3:0]  chunk_bytes,
	output logic        last,
	output logic [1:0]  error
);

	localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int ELW = $clog2(MAX_ENTRIES + 1);

	logic [7:0]  buf0 [MAX_KEY_BYTES];
	logic [7:0]  buf1 [MAX_KEY_BYTES];
	logic [31:0] offs [MAX_ENTRIES];

	logic [7:0]     rd0_q, rd1_q;
	logic [31:0]    ord_q;
	logic           sel_q;
	logic [KLW-1:0] plen_q, blen_q, kidx_q;
	logic           trunc_q;
	logic [ELW-1:0] cnt_q, eidx_q;
	logic [31:0]    clen_q, crc_q;
	logic           first_q;
	logic [1:0]     err_q;
	logic [31:0]    word_q;
	logic [1:0]     bsel_q;
	logic           wcnt_q, wfin_q;
	logic [63:0]    acc_q;
	logic [3:0]     fill_q;
	logic           ovalid_q;
	logic [63:0]    odata_q;
	logic [3:0]     obytes_q;
	logic           olast_q;
	logic [1:0]     oerr_q;

	logic           key_wr, end_take, val_take, fin_take, key_room, drop;
	logic [7:0]     bdat, pdat;
	logic [KLW-1:0] lim;
	logic           put_en, put_cnt, put_fin, push, can_push;
	logic [7:0]     put_b;
	logic [1:0]     put_err;
	logic [63:0]    acc_n;
	logic [3:0]     fill_n;
	logic [31:0]    crc_n;

	assign key_room = plen_q < KLW'(MAX_KEY_BYTES);
	assign key_wr   = ctl.take && cmd_t'(cmd) == CMD_KEY;
	assign end_take = ctl.take && cmd_t'(cmd) == CMD_END;
	assign val_take = ctl.take && cmd_t'(cmd) == CMD_VAL;
	assign fin_take = ctl.take && cmd_t'(cmd) == CMD_FIN;
	assign drop     = cnt_q == ELW'(MAX_ENTRIES);

	always_ff @(posedge clk) begin
		if (key_wr && key_room && sel_q) buf0[plen_q[KAW-1:0]] <= data;
		rd0_q <= buf0[kidx_q[KAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (key_wr && key_room && !sel_q) buf1[plen_q[KAW-1:0]] <= data;
		rd1_q <= buf1[kidx_q[KAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (end_take && !drop) offs[cnt_q[EAW-1:0]] <= clen_q;
		ord_q <= offs[eidx_q[EAW-1:0]];
	end

	assign bdat = sel_q ? rd1_q : rd0_q;
	assign pdat = sel_q ? rd0_q : rd1_q;
	assign lim  = (blen_q < plen_q) ? blen_q : plen_q;

	assign can_push = !ovalid_q || out_ready;

	assign sts.first     = first_q;
	assign sts.cmp_more  = (kidx_q < lim) && (bdat == pdat);
	assign sts.suf_left  = kidx_q < plen_q;
	assign sts.word_last = bsel_q == 2'd3;
	assign sts.ent_left  = eidx_q < cnt_q;
	assign sts.can_push  = can_push;

	always_comb begin
		put_en  = 1'b0;
		put_b   = 8'd0;
		put_cnt = 1'b0;
		put_fin = 1'b0;
		put_err = ERR_NONE;
		if (val_take) begin
			put_en  = 1'b1;
			put_b   = data;
			put_cnt = 1'b1;
			put_fin = 1'b1;
		end else if (ctl.suf_put) begin
			put_en  = 1'b1;
			put_b   = pdat;
			put_cnt = 1'b1;
			put_fin = (kidx_q + KLW'(1)) == plen_q;
			put_err = err_q;
		end else if (ctl.word_put) begin
			put_en  = 1'b1;
			put_b   = word_q[{bsel_q, 3'b000} +: 8];
			put_cnt = wcnt_q;
			put_fin = wfin_q && (bsel_q == 2'd3);
			put_err = err_q;
		end
	end

	assign crc_n  = crc32c_byte(crc_q, put_b);
	assign acc_n  = acc_q | (64'(put_b) << {fill_q[2:0], 3'b000});
	assign fill_n = fill_q + 4'd1;
	assign push   = put_en && (fill_n == 4'd8 || put_fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= 1'b0;
			plen_q  <= '0;
			blen_q  <= '0;
			kidx_q  <= '0;
			trunc_q <= 1'b0;
			cnt_q   <= '0;
			eidx_q  <= '0;
			clen_q  <= '0;
			crc_q   <= CRC_INIT;
			first_q <= 1'b0;
			err_q   <= ERR_NONE;
			word_q  <= '0;
			bsel_q  <= '0;
			wcnt_q  <= 1'b0;
			wfin_q  <= 1'b0;
			acc_q   <= '0;
			fill_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (key_wr) begin
				if (key_room) plen_q <= plen_q + KLW'(1);
				else trunc_q <= 1'b1;
			end
			if (end_take) begin
				first_q <= cnt_q == '0;
				err_q   <= drop ? ERR_DROP : (trunc_q ? ERR_TRUNC : ERR_NONE);
				kidx_q  <= '0;
				if (!drop) cnt_q <= cnt_q + ELW'(1);
			end
			if (fin_take) begin
				eidx_q <= '0;
				err_q  <= ERR_NONE;
			end
			if (ctl.first_sel) begin
				sel_q  <= !sel_q;
				blen_q <= plen_q;
				kidx_q <= plen_q;
			end
			if (ctl.cmp_inc || ctl.suf_put) kidx_q <= kidx_q + KLW'(1);
			if (ctl.hdr_load) begin
				word_q <= {16'(plen_q - kidx_q), 16'(kidx_q)};
				wcnt_q <= 1'b1;
				wfin_q <= kidx_q == plen_q;
				bsel_q <= '0;
			end
			if (ctl.off_load) begin
				word_q <= ord_q;
				wcnt_q <= 1'b1;
				wfin_q <= 1'b0;
				bsel_q <= '0;
				eidx_q <= eidx_q + ELW'(1);
			end
			if (ctl.cnt_load) begin
				word_q <= 32'(cnt_q);
				wcnt_q <= 1'b1;
				wfin_q <= 1'b0;
				bsel_q <= '0;
			end
			if (ctl.crc_load) begin
				word_q <= ~crc_q;
				wcnt_q <= 1'b0;
				wfin_q <= 1'b0;
				bsel_q <= '0;
			end
			if (ctl.four_load) begin
				word_q <= TRAILER_MAGIC;
				wcnt_q <= 1'b0;
				wfin_q <= 1'b1;
				bsel_q <= '0;
			end
			if (ctl.word_put) bsel_q <= bsel_q + 2'd1;
			if (ctl.key_done) begin
				plen_q  <= '0;
				trunc_q <= 1'b0;
			end
			if (put_en && put_cnt) begin
				crc_q  <= crc_n;
				clen_q <= clen_q + 32'd1;
			end
			if (put_en) begin
				if (push) begin
					acc_q  <= '0;
					fill_q <= '0;
				end else begin
					acc_q  <= acc_n;
					fill_q <= fill_n;
				end
			end
			if (ctl.clear) begin
				plen_q  <= '0;
				blen_q  <= '0;
				cnt_q   <= '0;
				clen_q  <= '0;
				crc_q   <= CRC_INIT;
				trunc_q <= 1'b0;
			end
			if (push) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			odata_q  <= acc_n;
			obytes_q <= fill_n;
			olast_q  <= put_fin;
			oerr_q   <= put_err;
		end
	end

	assign out_valid   = ovalid_q;
	assign chunk_data  = odata_q;
	assign chunk_bytes = obytes_q;
	assign last        = olast_q;
	assign error       = oerr_q;

	assert property (@(posedge clk) disable iff (!arst_n) push |-> can_push)
		else $error("result pushed over an untaken result");

	assert property (@(posedge clk) disable iff (!arst_n) fill_q < 4'd8)
		else $error("packer fill overflow");

	assert property (@(posedge clk) disable iff (!arst_n) ctl.suf_put |-> kidx_q < plen_q)
		else $error("suffix read past pending key");

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= ELW'(MAX_ENTRIES))
		else $error("entry count beyond table");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the prefix-compressed key-value block encoder against an in-bench
// model of its byte stream, with random idling on both channels.
// ---------------------------------------------------------------------------
module testbench import kvbpe_pkg::*; ();

	localparam int KEY_MAX = MAX_KEY_BYTES_DEF;
	localparam int ENT_MAX = MAX_ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [63:0] chunk;
		logic [3:0]  nbytes;
		logic        fin;
		logic [1:0]  err;
	} chunk_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_KEY;
	logic [7:0]  data = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] chunk_data;
	logic [3:0]  chunk_bytes;
	logic        last;
	logic [1:0]  error;

	kv_block_prefix_encoder_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.chunk_data(chunk_data), .chunk_bytes(chunk_bytes), .last(last), .error(error)
	);

	always #5 clk = ~clk;

	// block model state
	logic [7:0]  root_key[KEY_MAX];
	int          base_len;
	logic [7:0]  pend_key[KEY_MAX];
	int          pend_len;
	logic [31:0] offsets[ENT_MAX];
	int          n_entries;
	logic [31:0] stream_len;
	logic [31:0] crc_acc;
	logic        trunc_flag;

	chunk_t      expected_chunks[$];
	logic [63:0] acc;
	int          fill;
	logic [1:0]  cur_err;
	int          start_idx;

	int  errors = 0;
	int  sent = 0;
	int  got = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;

	task automatic clear_block();
		base_len = 0;
		pend_len = 0;
		n_entries = 0;
		stream_len = 0;
		crc_acc = 32'hFFFF_FFFF;
		trunc_flag = 1'b0;
	endtask

	task automatic flush_chunk();
		chunk_t nc;
		if (fill != 0) begin
			nc = '{acc, fill[3:0], 1'b0, cur_err};
			expected_chunks.insert(expected_chunks.size(), nc);
			acc = '0;
			fill = 0;
		end
	endtask

	task automatic emit_byte(input logic [7:0] b, input bit counted);
		logic [31:0] c;
		if (counted) begin
			c = crc_acc ^ {24'd0, b};
			for (int k = 0; k < 8; k++)
				c = (c >> 1) ^ (32'h82F63B78 & {32{c[0]}});
			crc_acc = c;
			stream_len = stream_len + 1;
		end
		acc[8 * fill +: 8] = b;
		fill++;
		if (fill == 8)
			flush_chunk();
	endtask

	task automatic emit_word(input logic [31:0] w, input bit counted);
		for (int k = 0; k < 4; k++)
			emit_byte(w[8 * k +: 8], counted);
	endtask

	task automatic predict_block(input logic [1:0] c, input logic [7:0] d);
		int shared;
		int lim;
		logic [31:0] start;
		bit dropped;
		acc = '0;
		fill = 0;
		cur_err = ERR_NONE;
		start_idx = expected_chunks.size();
		case (c)
			CMD_KEY: begin
				if (pend_len < KEY_MAX) begin
					pend_key[pend_len] = d;
					pend_len++;
				end else
					trunc_flag = 1'b1;
			end
			CMD_END: begin
				start = stream_len;
				dropped = n_entries >= ENT_MAX;
				cur_err = dropped ? ERR_DROP : (trunc_flag ? ERR_TRUNC : ERR_NONE);
				if (n_entries == 0) begin
					for (int k = 0; k < pend_len; k++)
						root_key[k] = pend_key[k];
					base_len = pend_len;
					shared = pend_len;
				end else begin
					lim = pend_len < base_len ? pend_len : base_len;
					shared = 0;
					while (shared < lim && root_key[shared] == pend_key[shared])
						shared++;
				end
				emit_word({16'(pend_len - shared), 16'(shared)}, 1'b1);
				for (int k = shared; k < pend_len; k++)
					emit_byte(pend_key[k], 1'b1);
				if (!dropped) begin
					offsets[n_entries] = start;
					n_entries++;
				end
				pend_len = 0;
				trunc_flag = 1'b0;
			end
			CMD_VAL: emit_byte(d, 1'b1);
			default: begin
				for (int k = 0; k < n_entries; k++)
					emit_word(offsets[k], 1'b1);
				emit_word(32'(n_entries), 1'b1);
				emit_word(~crc_acc, 1'b0);
				emit_word(TRAILER_MAGIC, 1'b0);
				clear_block();
			end
		endcase
		flush_chunk();
		if (expected_chunks.size() > start_idx)
			expected_chunks[expected_chunks.size() - 1].fin = 1'b1;
	endtask

	task automatic send_item(input logic [1:0] c, input logic [7:0] d);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		predict_block(c, d);
		in_valid <= 1'b1;
		cmd <= c;
		data <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_key(input int len, input bit rnd_tail);
		for (int k = 0; k < len; k++)
			send_item(CMD_KEY, rnd_tail ? 8'($urandom) : root_key[k % KEY_MAX]);
	endtask

	// output side: random stall bursts
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (idle_on && $urandom_range(0, 7) == 0)
			out_ready <= 1'b0;
		else if (!out_ready && idle_on && $urandom_range(0, 2) != 0)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		chunk_t e;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			got++;
			if (expected_chunks.size() == 0) begin
				$display("%0t: unexpected transaction data=%h", $time, chunk_data);
				errors++;
			end else begin
				e = expected_chunks.pop_front();
				if (chunk_data !== e.chunk || chunk_bytes !== e.nbytes ||
					last !== e.fin || error !== e.err) begin
					$display("%0t: mismatch expected %h/%0d/%0b/%0d actual %h/%0d/%0b/%0d",
						$time, e.chunk, e.nbytes, e.fin, e.err,
						chunk_data, chunk_bytes, last, error);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_empty_and_values();
		send_item(CMD_FIN, 8'h00);
		send_item(CMD_VAL, 8'h00);
		send_item(CMD_VAL, 8'hFF);
		send_item(CMD_END, 8'h00);
		send_item(CMD_FIN, 8'hA5);
	endtask

	task automatic test_prefix_keys();
		send_item(CMD_KEY, 8'h61);
		send_item(CMD_KEY, 8'h62);
		send_item(CMD_KEY, 8'hFF);
		send_item(CMD_END, 8'h00);
		send_item(CMD_KEY, 8'h61);
		send_item(CMD_KEY, 8'h00);
		send_item(CMD_END, 8'hFF);
		send_item(CMD_VAL, 8'h55);
		send_item(CMD_KEY, 8'h61);
		send_item(CMD_KEY, 8'h62);
		send_item(CMD_KEY, 8'hFF);
		send_item(CMD_KEY, 8'h01);
		send_item(CMD_END, 8'h00);
		send_item(CMD_KEY, 8'h07);
		send_item(CMD_FIN, 8'h00);
	endtask

	task automatic test_long_key();
		send_key(KEY_MAX + 3, 1'b1);
		send_item(CMD_END, 8'h00);
		send_key(KEY_MAX, 1'b0);
		send_item(CMD_END, 8'h00);
		send_item(CMD_FIN, 8'h00);
	endtask

	task automatic test_entry_overflow();
		for (int n = 0; n < ENT_MAX + 3; n++) begin
			send_key($urandom_range(0, 3), 1'b1);
			if (n == ENT_MAX + 1)
				send_key(KEY_MAX + 1, 1'b1);
			send_item(CMD_END, 8'h00);
		end
		send_item(CMD_FIN, 8'h00);
	endtask

	task automatic test_random_blocks(input int n_items);
		int r;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				// well-formed entry: key sharing some prefix, then value bytes
				send_key($urandom_range(0, base_len < 1 ? 0 : base_len), 1'b0);
				send_key($urandom_range(0, 4), 1'b1);
				send_item(CMD_END, 8'($urandom));
				repeat ($urandom_range(0, 4))
					send_item(CMD_VAL, 8'($urandom));
			end else if (r < 92)
				send_item(2'($urandom), 8'($urandom));
			else
				send_item(CMD_FIN, 8'($urandom));
		end
		send_item(CMD_FIN, 8'h00);
	endtask

	initial begin
		clear_block();
		for (int k = 0; k < KEY_MAX; k++)
			root_key[k] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_values();
		test_prefix_keys();
		test_long_key();
		test_entry_overflow();
		test_random_blocks(sent + 60);
		idle_on = 1'b0;
		test_random_blocks(sent + 25);
		in_valid <= 1'b0;
		while (expected_chunks.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d input transactions, checked %0d output transactions,", sent, got);
		$display("covering prefix sharing, long keys, entry overflow and block trailers.");
		if (errors == 0 && expected_chunks.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
rtl/kvbpe_pkg.sv
rtl/kvbpe_ctrl.sv
rtl/kvbpe_dp.sv
rtl/kv_block_prefix_encoder_core.sv
tb/sv/testbench.sv
